### rtl/core/ucfl_pkg.sv
// Types, constants and helpers of the unicycle feedback linearization core.
package ucfl_pkg;

  // Q format of registers and ports; the modulus constants below assume this value.
  localparam int FRAC_BITS = 16;
  localparam int ATAN_LEN  = 24;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_RADIUS       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ANGULAR_RATE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INV_OFFSET_X = 3'd5;

  localparam logic signed [31:0] RST_RADIUS       = 32'sd65536;
  localparam logic signed [31:0] RST_ANGULAR_RATE = 32'sd411775;
  localparam logic signed [31:0] RST_GAIN         = 32'sd65536;
  localparam logic signed [31:0] RST_OFFSET_X     = 32'sd6554;
  localparam logic signed [31:0] RST_OFFSET_Y     = 32'sd0;
  localparam logic signed [31:0] RST_INV_OFFSET_X = 32'sd655360;

  localparam logic signed [36:0] PI_Q30      = 37'sd3373259426;
  localparam logic signed [36:0] HALF_PI_Q30 = 37'sd1686629713;
  localparam logic signed [36:0] TWO_PI_Q30  = 37'sd6746518852;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

  // two pi with 2*FRAC_BITS fraction bits (angle w*t) and FRAC_BITS (heading)
  localparam logic signed [36:0] TWO_PI_QA = 37'sd26986075409;
  localparam logic signed [20:0] TWO_PI_QH = 21'sd411775;
  // scaled reciprocals for the quotient estimates
  localparam logic signed [29:0] RECIP_QA = 30'((64'd1 << 62) / 64'd26986075409);
  localparam logic signed [23:0] RECIP_QH = 24'((64'd1 << 40) / 64'd411775);

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
  };

  typedef struct packed {
    logic [31:0]        t;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } side_t;

  typedef struct packed {
    logic [31:0]        t;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
  } res_t;

  typedef struct packed {
    logic               neg;
    logic signed [33:0] z;
  } fold_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // fold a Q30 angle in [0, 2pi) into [-pi/2, pi/2]; neg marks a removed half turn
  function automatic fold_t fold(input logic signed [36:0] a);
    logic signed [36:0] b;
    fold_t r;
    b = a;
    r.neg = 1'b0;
    if (b > PI_Q30) begin
      b = b - TWO_PI_Q30;
    end
    if (b > HALF_PI_Q30) begin
      b = b - PI_Q30;
      r.neg = 1'b1;
    end else if (b < -HALF_PI_Q30) begin
      b = b + PI_Q30;
      r.neg = 1'b1;
    end
    r.z = 34'(b);
    return r;
  endfunction

endpackage

### rtl/core/unicycle_feedback_linearization_core.sv
// Top level: pipelined unicycle tracking controller by feedback linearization.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o      | time_now, pose_x, pose_y, heading
//  out     | output    | out_valid_o / out_stall_i    | time_stamp, lin_velocity, ang_velocity,
//          |           |                              | ref_x, ref_y, point_x, point_y
//  cfg     | input     | cfg_we_i, cfg_idx_i          | cfg_data_i
//
// One item per cycle while the output is not stalled. The pipeline has five
// angle reduction stages, one CORDIC iteration per stage, and ten stages of products and sums.
// Reset clears the valid bits and loads the register reset values.
// A held result at the output freezes the whole pipeline; the input stalls in that cycle.
module unicycle_feedback_linearization_core #(
  parameter int CORDIC_ITERS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [31:0]                        time_now_i,
  input  logic signed [31:0]                 pose_x_i,
  input  logic signed [31:0]                 pose_y_i,
  input  logic signed [31:0]                 heading_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [31:0]                        time_stamp_o,
  output logic signed [31:0]                 lin_velocity_o,
  output logic signed [31:0]                 ang_velocity_o,
  output logic signed [31:0]                 ref_x_o,
  output logic signed [31:0]                 ref_y_o,
  output logic signed [31:0]                 point_x_o,
  output logic signed [31:0]                 point_y_o,
  input  logic                               cfg_we_i,
  input  logic [ucfl_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [31:0]                        cfg_data_i
);

  localparam int NST  = 15 + CORDIC_ITERS;
  localparam int LAST = CORDIC_ITERS - 1;
  localparam int FB   = ucfl_pkg::FRAC_BITS;

  // ---------------- configuration registers ----------------
  logic signed [31:0] radius_q, rate_q, gain_q, xr_q, yr_q, inv_q;
  logic signed [31:0] rw_q, k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= ucfl_pkg::RST_RADIUS;
      rate_q   <= ucfl_pkg::RST_ANGULAR_RATE;
      gain_q   <= ucfl_pkg::RST_GAIN;
      xr_q     <= ucfl_pkg::RST_OFFSET_X;
      yr_q     <= ucfl_pkg::RST_OFFSET_Y;
      inv_q    <= ucfl_pkg::RST_INV_OFFSET_X;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ucfl_pkg::REG_RADIUS:       radius_q <= cfg_data_i;
        ucfl_pkg::REG_ANGULAR_RATE: rate_q   <= cfg_data_i;
        ucfl_pkg::REG_GAIN:         gain_q   <= cfg_data_i;
        ucfl_pkg::REG_OFFSET_X:     xr_q     <= cfg_data_i;
        ucfl_pkg::REG_OFFSET_Y:     yr_q     <= cfg_data_i;
        ucfl_pkg::REG_INV_OFFSET_X: inv_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // register-only terms R*w and yr/xr
  always_ff @(posedge clk_i) begin
    rw_q <= ucfl_pkg::sat32(72'((64'(radius_q) * 64'(rate_q)) >>> FB));
    k_q  <= ucfl_pkg::sat32(72'((64'(yr_q) * 64'(inv_q)) >>> FB));
  end

  // ---------------- pipeline control ----------------
  logic [NST-1:0] v_q;
  logic           adv;

  assign adv        = !v_q[NST-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  // ---------------- P0: w*t and heading quotient products ----------------
  logic signed [63:0] p0_vprod_q;
  logic signed [55:0] p0_hprod_q;
  logic signed [31:0] p0_th_q;
  ucfl_pkg::side_t    p0_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_vprod_q <= 64'(rate_q) * 64'($signed({1'b0, time_now_i}));
      p0_hprod_q <= 56'(heading_i) * 56'(ucfl_pkg::RECIP_QH);
      p0_th_q    <= heading_i;
      p0_side_q  <= '{t: time_now_i, px: pose_x_i, py: pose_y_i};
    end
  end

  // ---------------- P1: quotient estimates ----------------
  logic signed [63:0] p1_vprod_q;
  logic signed [31:0] p1_vq_q;
  logic signed [21:0] p1_hr_q;
  ucfl_pkg::side_t    p1_side_q;
  logic signed [39:0] p1_hr;

  // heading remainder biased by one modulus, lands in [0, 3m)
  assign p1_hr = 40'(p0_th_q) - 40'(p0_hprod_q >>> 40) * 40'(ucfl_pkg::TWO_PI_QH)
               + 40'(ucfl_pkg::TWO_PI_QH);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_vq_q    <= 32'(((p0_vprod_q >>> 32) * 64'(ucfl_pkg::RECIP_QA)) >>> 30);
      p1_vprod_q <= p0_vprod_q;
      p1_hr_q    <= 22'(p1_hr);
      p1_side_q  <= p0_side_q;
    end
  end

  // ---------------- P2: biased angle remainder, heading correction ----------------
  logic signed [39:0] p2_vr_q;
  logic signed [36:0] p2_ha_q;
  ucfl_pkg::side_t    p2_side_q;
  logic signed [21:0] p2_hr;

  always_comb begin
    if (p1_hr_q >= 22'(ucfl_pkg::TWO_PI_QH) * 22'sd2) begin
      p2_hr = p1_hr_q - 22'(ucfl_pkg::TWO_PI_QH) * 22'sd2;
    end else if (p1_hr_q >= 22'(ucfl_pkg::TWO_PI_QH)) begin
      p2_hr = p1_hr_q - 22'(ucfl_pkg::TWO_PI_QH);
    end else begin
      p2_hr = p1_hr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // bias by three moduli so the remainder lands in [0, 8m)
      p2_vr_q   <= 40'(72'(p1_vprod_q) - 72'(p1_vq_q) * 72'(ucfl_pkg::TWO_PI_QA)
                       + 72'(ucfl_pkg::TWO_PI_QA) * 72'sd3);
      p2_ha_q   <= 37'(p2_hr) <<< (30 - FB);
      p2_side_q <= p1_side_q;
    end
  end

  // ---------------- P3: angle remainder correction ----------------
  logic signed [36:0] p3_va_q;
  logic signed [36:0] p3_ha_q;
  ucfl_pkg::side_t    p3_side_q;
  logic [2:0]         p3_k;
  logic signed [39:0] p3_vr;

  always_comb begin
    p3_k = 3'd0;
    for (int j = 1; j < 8; j++) begin
      if (p2_vr_q >= 40'(ucfl_pkg::TWO_PI_QA) * 40'(j)) begin
        p3_k = 3'(j);
      end
    end
    p3_vr = p2_vr_q - 40'(ucfl_pkg::TWO_PI_QA) * $signed({37'd0, p3_k});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_va_q   <= 37'(p3_vr >>> (2 * FB - 30));
      p3_ha_q   <= p2_ha_q;
      p3_side_q <= p2_side_q;
    end
  end

  // ---------------- P4: fold both angles ----------------
  ucfl_pkg::fold_t p4_a_q, p4_h_q;
  ucfl_pkg::side_t p4_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_a_q    <= ucfl_pkg::fold(p3_va_q);
      p4_h_q    <= ucfl_pkg::fold(p3_ha_q);
      p4_side_q <= p3_side_q;
    end
  end

  // ---------------- CORDIC: one iteration per stage, both angles ----------------
  logic signed [33:0] ax_q [CORDIC_ITERS];
  logic signed [33:0] ay_q [CORDIC_ITERS];
  logic signed [33:0] az_q [CORDIC_ITERS];
  logic signed [33:0] hx_q [CORDIC_ITERS];
  logic signed [33:0] hy_q [CORDIC_ITERS];
  logic signed [33:0] hz_q [CORDIC_ITERS];
  logic               aneg_q [CORDIC_ITERS];
  logic               hneg_q [CORDIC_ITERS];
  ucfl_pkg::side_t    cs_q [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    localparam logic signed [33:0] ATAN_I = 34'(ucfl_pkg::ATAN_Q30[i]);
    logic signed [33:0] axi, ayi, azi, hxi, hyi, hzi;
    logic               anegi, hnegi;
    ucfl_pkg::side_t    si;

    if (i == 0) begin : g_first
      assign axi   = ucfl_pkg::CORDIC_K_Q30;
      assign ayi   = '0;
      assign azi   = p4_a_q.z;
      assign hxi   = ucfl_pkg::CORDIC_K_Q30;
      assign hyi   = '0;
      assign hzi   = p4_h_q.z;
      assign anegi = p4_a_q.neg;
      assign hnegi = p4_h_q.neg;
      assign si    = p4_side_q;
    end else begin : g_next
      assign axi   = ax_q[i-1];
      assign ayi   = ay_q[i-1];
      assign azi   = az_q[i-1];
      assign hxi   = hx_q[i-1];
      assign hyi   = hy_q[i-1];
      assign hzi   = hz_q[i-1];
      assign anegi = aneg_q[i-1];
      assign hnegi = hneg_q[i-1];
      assign si    = cs_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (azi >= 0) begin
          ax_q[i] <= axi - (ayi >>> i);
          ay_q[i] <= ayi + (axi >>> i);
          az_q[i] <= azi - ATAN_I;
        end else begin
          ax_q[i] <= axi + (ayi >>> i);
          ay_q[i] <= ayi - (axi >>> i);
          az_q[i] <= azi + ATAN_I;
        end
        if (hzi >= 0) begin
          hx_q[i] <= hxi - (hyi >>> i);
          hy_q[i] <= hyi + (hxi >>> i);
          hz_q[i] <= hzi - ATAN_I;
        end else begin
          hx_q[i] <= hxi + (hyi >>> i);
          hy_q[i] <= hyi - (hxi >>> i);
          hz_q[i] <= hzi + ATAN_I;
        end
        aneg_q[i] <= anegi;
        hneg_q[i] <= hnegi;
        cs_q[i]   <= si;
      end
    end
  end

  // ---------------- S0: undo the half turn ----------------
  logic signed [33:0] s0_ct_q, s0_st_q, s0_ch_q, s0_sh_q;
  ucfl_pkg::side_t    s0_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_ct_q   <= aneg_q[LAST] ? -ax_q[LAST] : ax_q[LAST];
      s0_st_q   <= aneg_q[LAST] ? -ay_q[LAST] : ay_q[LAST];
      s0_ch_q   <= hneg_q[LAST] ? -hx_q[LAST] : hx_q[LAST];
      s0_sh_q   <= hneg_q[LAST] ? -hy_q[LAST] : hy_q[LAST];
      s0_side_q <= cs_q[LAST];
    end
  end

  // ---------------- S1: reference and controlled point products ----------------
  logic signed [67:0] s1_pxd_q, s1_pyd_q, s1_prx_q, s1_pry_q;
  logic signed [67:0] s1_p1_q, s1_p2_q, s1_p3_q, s1_p4_q;
  logic signed [33:0] s1_ch_q, s1_sh_q;
  ucfl_pkg::side_t    s1_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pxd_q  <= 68'(rw_q) * 68'(s0_st_q);
      s1_pyd_q  <= 68'(rw_q) * 68'(s0_ct_q);
      s1_prx_q  <= 68'(radius_q) * (68'(s0_ct_q) - 68'(ucfl_pkg::ONE_Q30));
      s1_pry_q  <= 68'(radius_q) * 68'(s0_st_q);
      s1_p1_q   <= 68'(xr_q) * 68'(s0_ch_q);
      s1_p2_q   <= 68'(yr_q) * 68'(s0_sh_q);
      s1_p3_q   <= 68'(xr_q) * 68'(s0_sh_q);
      s1_p4_q   <= 68'(yr_q) * 68'(s0_ch_q);
      s1_ch_q   <= s0_ch_q;
      s1_sh_q   <= s0_sh_q;
      s1_side_q <= s0_side_q;
    end
  end

  // ---------------- S2: rescale and saturate ----------------
  logic signed [31:0] s2_xd_q, s2_yd_q;
  logic signed [33:0] s2_ch_q, s2_sh_q;
  ucfl_pkg::res_t     s2_res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_xd_q  <= ucfl_pkg::sat32((-72'(s1_pxd_q)) >>> 30);
      s2_yd_q  <= ucfl_pkg::sat32(72'(s1_pyd_q) >>> 30);
      s2_res_q <= '{
        t:  s1_side_q.t,
        rx: ucfl_pkg::sat32(72'(s1_prx_q) >>> 30),
        ry: ucfl_pkg::sat32(72'(s1_pry_q) >>> 30),
        qx: ucfl_pkg::sat32(72'(s1_side_q.px) + (72'(s1_p1_q) >>> 30)
                            - (72'(s1_p2_q) >>> 30)),
        qy: ucfl_pkg::sat32(72'(s1_side_q.py) + (72'(s1_p3_q) >>> 30)
                            + (72'(s1_p4_q) >>> 30))
      };
      s2_ch_q  <= s1_ch_q;
      s2_sh_q  <= s1_sh_q;
    end
  end

  // ---------------- S3: position error ----------------
  logic signed [31:0] s3_ex_q, s3_ey_q, s3_xd_q, s3_yd_q;
  logic signed [33:0] s3_ch_q, s3_sh_q;
  ucfl_pkg::res_t     s3_res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ex_q  <= ucfl_pkg::sat32(72'(s2_res_q.rx) - 72'(s2_res_q.qx));
      s3_ey_q  <= ucfl_pkg::sat32(72'(s2_res_q.ry) - 72'(s2_res_q.qy));
      s3_xd_q  <= s2_xd_q;
      s3_yd_q  <= s2_yd_q;
      s3_ch_q  <= s2_ch_q;
      s3_sh_q  <= s2_sh_q;
      s3_res_q <= s2_res_q;
    end
  end

  // ---------------- S4: proportional gain ----------------
  logic signed [63:0] s4_pkx_q, s4_pky_q;
  logic signed [31:0] s4_xd_q, s4_yd_q;
  logic signed [33:0] s4_ch_q, s4_sh_q;
  ucfl_pkg::res_t     s4_res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_pkx_q <= 64'(gain_q) * 64'(s3_ex_q);
      s4_pky_q <= 64'(gain_q) * 64'(s3_ey_q);
      s4_xd_q  <= s3_xd_q;
      s4_yd_q  <= s3_yd_q;
      s4_ch_q  <= s3_ch_q;
      s4_sh_q  <= s3_sh_q;
      s4_res_q <= s3_res_q;
    end
  end

  // ---------------- S5: add feedforward ----------------
  logic signed [31:0] s5_vx_q, s5_vy_q;
  logic signed [33:0] s5_ch_q, s5_sh_q;
  ucfl_pkg::res_t     s5_res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_vx_q  <= ucfl_pkg::sat32((72'(s4_pkx_q) >>> FB) + 72'(s4_xd_q));
      s5_vy_q  <= ucfl_pkg::sat32((72'(s4_pky_q) >>> FB) + 72'(s4_yd_q));
      s5_ch_q  <= s4_ch_q;
      s5_sh_q  <= s4_sh_q;
      s5_res_q <= s4_res_q;
    end
  end

  // ---------------- S6: rotate into the body frame ----------------
  logic signed [65:0] s6_a1_q, s6_a2_q, s6_a3_q, s6_a4_q;
  ucfl_pkg::res_t     s6_res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_a1_q  <= 66'(s5_vx_q) * 66'(s5_ch_q);
      s6_a2_q  <= 66'(s5_vy_q) * 66'(s5_sh_q);
      s6_a3_q  <= 66'(s5_vy_q) * 66'(s5_ch_q);
      s6_a4_q  <= 66'(s5_vx_q) * 66'(s5_sh_q);
      s6_res_q <= s5_res_q;
    end
  end

  // ---------------- S7: body velocities ----------------
  logic signed [31:0] s7_u_q, s7_w_q;
  ucfl_pkg::res_t     s7_res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_u_q   <= ucfl_pkg::sat32((72'(s6_a1_q) >>> 30) + (72'(s6_a2_q) >>> 30));
      s7_w_q   <= ucfl_pkg::sat32((72'(s6_a3_q) >>> 30) - (72'(s6_a4_q) >>> 30));
      s7_res_q <= s6_res_q;
    end
  end

  // ---------------- S8: offset inversion products ----------------
  logic signed [63:0] s8_pk_q, s8_pw_q;
  logic signed [31:0] s8_u_q;
  ucfl_pkg::res_t     s8_res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_pk_q  <= 64'(k_q) * 64'(s7_w_q);
      s8_pw_q  <= 64'(s7_w_q) * 64'(inv_q);
      s8_u_q   <= s7_u_q;
      s8_res_q <= s7_res_q;
    end
  end

  // ---------------- S9: output register ----------------
  logic signed [31:0] s9_lin_q, s9_ang_q;
  ucfl_pkg::res_t     s9_res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_lin_q <= ucfl_pkg::sat32(72'(s8_u_q) + (72'(s8_pk_q) >>> FB));
      s9_ang_q <= ucfl_pkg::sat32(72'(s8_pw_q) >>> FB);
      s9_res_q <= s8_res_q;
    end
  end

  assign out_valid_o    = v_q[NST-1];
  assign time_stamp_o   = s9_res_q.t;
  assign lin_velocity_o = s9_lin_q;
  assign ang_velocity_o = s9_ang_q;
  assign ref_x_o        = s9_res_q.rx;
  assign ref_y_o        = s9_res_q.ry;
  assign point_x_o      = s9_res_q.qx;
  assign point_y_o      = s9_res_q.qy;

endmodule
